// File: rtl/core/piaw_pkg.sv
// Shared constants for the PI controller core: data width and the
// configuration register map. No dependencies.
package piaw_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic signed [DATA_W-1:0] q16_t;

  localparam cfg_idx_t REG_SOURCE_SELECT = 3'd0;
  localparam cfg_idx_t REG_PROP_GAIN     = 3'd1;
  localparam cfg_idx_t REG_INTEG_GAIN    = 3'd2;
  localparam cfg_idx_t REG_OFFSET_TERM   = 3'd3;
  localparam cfg_idx_t REG_REF_GAIN      = 3'd4;
  localparam cfg_idx_t REG_UPPER_BOUND   = 3'd5;
  localparam cfg_idx_t REG_LOWER_BOUND   = 3'd6;

  localparam logic [1:0] SRC_OFF      = 2'd0;
  localparam logic [1:0] SRC_FLOW     = 2'd1;
  localparam logic [1:0] SRC_GAS      = 2'd2;
  localparam logic [1:0] SRC_RESERVED = 2'd3;

endpackage

// File: rtl/core/pi_controller_antiwindup_feedforward_core.sv
// PI controller with feedforward and back-calculation anti-windup, Q16.16.
// Depends on piaw_pkg for the data width and the register map.

// One input word is one control tick and yields one output word. A tick
// runs S_INT, S_M1, S_M2, S_M3 and S_CLAMP, then S_WRITE, which loads the
// output register, when the drive is not clamped or the integral gain is
// zero; when it is clamped it runs S_DIFF, S_ABS and S_OVF, then S_SAT if
// the back-calculated integral is known to saturate, else S_DIV first. A
// single 32x32 multiplier is used three times in a row, and the
// back-calculation runs a restoring divider that produces one quotient bit
// per cycle. With the source off an accepted tick goes straight to S_WRITE.
// The input stalls for the whole tick and accepts the next word at the edge
// after the result has moved into the output register, even while that
// register still waits for the consumer; a stalled consumer holds the tick
// in its last state until the output register is free.
// Source 0 clears the integral and outputs zero. Configuration writes are
// always ready and must be issued while no tick is in progress.
module pi_controller_antiwindup_feedforward_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  piaw_pkg::q16_t             in_flow_measure,
  input  piaw_pkg::q16_t             in_flow_target,
  input  piaw_pkg::q16_t             in_gas_measure,
  input  piaw_pkg::q16_t             in_gas_limit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output piaw_pkg::q16_t             out_drive_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  piaw_pkg::cfg_idx_t         cfg_index,
  input  logic [piaw_pkg::DATA_W-1:0] cfg_data
);
  import piaw_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INT   = 4'd1;
  localparam logic [3:0] S_M1    = 4'd2;
  localparam logic [3:0] S_M2    = 4'd3;
  localparam logic [3:0] S_M3    = 4'd4;
  localparam logic [3:0] S_CLAMP = 4'd5;
  localparam logic [3:0] S_DIFF  = 4'd6;
  localparam logic [3:0] S_ABS   = 4'd7;
  localparam logic [3:0] S_OVF   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_SAT   = 4'd10;
  localparam logic [3:0] S_WRITE = 4'd11;

  // Configuration and controller state.
  logic [1:0] src_r;
  q16_t       kp_r, ki_r, offs_r, rg_r, ub_r, lb_r;
  q16_t       integ_r, integ_nxt;
  logic [3:0] state_r, state_nxt;
  logic       out_valid_r;

  // Datapath registers.
  q16_t               ref_r, e_r, drive_r, out_drive_r;
  logic signed [63:0] prod_r, acc_r, u1_r;
  logic [31:0]        km_r, rem_r;
  logic [32:0]        quo_r;
  logic [5:0]         cnt_r;
  logic               neg_r, ovf_r;

  logic accept;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_drive_value = out_drive_r;

  function automatic q16_t sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat33 = v[32] ? q16_t'(32'sh80000000) : q16_t'(32'sh7FFFFFFF);
    end else begin
      sat33 = v[31:0];
    end
  endfunction

  // Source selection and saturated error at acceptance.
  q16_t ref_sel, meas_sel, e_sel;
  always_comb begin
    ref_sel  = '0;
    meas_sel = '0;
    unique case (src_r)
      SRC_FLOW: begin
        ref_sel  = in_flow_target;
        meas_sel = in_flow_measure;
      end
      SRC_GAS: begin
        ref_sel  = in_gas_limit;
        meas_sel = in_gas_measure;
      end
      SRC_OFF, SRC_RESERVED: begin
        ref_sel  = '0;
        meas_sel = '0;
      end
    endcase
    e_sel = sat33({ref_sel[31], ref_sel} - {meas_sel[31], meas_sel});
  end

  // The shared multiplier; its operands follow the sequencer.
  q16_t               mul_a, mul_b;
  logic signed [63:0] prod;
  always_comb begin
    unique case (state_r)
      S_INT:   begin mul_a = e_r;     mul_b = kp_r; end
      S_M1:    begin mul_a = rg_r;    mul_b = ref_r; end
      default: begin mul_a = integ_r; mul_b = ki_r; end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  // Products are floored by an arithmetic shift of the fraction bits.
  logic signed [63:0] prod_q;
  assign prod_q = {{16{prod_r[63]}}, prod_r[63:16]};

  // Clamp: the upper bound first, then the lower bound.
  logic signed [63:0] ub_ext, lb_ext, clamp_v;
  logic               clamped;
  always_comb begin
    ub_ext  = {{32{ub_r[31]}}, ub_r};
    lb_ext  = {{32{lb_r[31]}}, lb_r};
    clamp_v = acc_r;
    clamped = 1'b0;
    if (acc_r > ub_ext) begin
      clamp_v = ub_ext;
      clamped = 1'b1;
    end
    if (clamp_v < lb_ext) begin
      clamp_v = lb_ext;
      clamped = 1'b1;
    end
  end

  // One restoring division step.
  logic [32:0] trial;
  logic        q_bit;
  logic [31:0] rem_step;
  always_comb begin
    trial    = {rem_r, quo_r[32]};
    q_bit    = (trial >= {1'b0, km_r});
    rem_step = q_bit ? 32'(trial - {1'b0, km_r}) : trial[31:0];
  end

  logic ovf_now;
  assign ovf_now = (acc_r >= {15'd0, km_r, 17'd0});

  // Saturated back-calculated integral from the quotient.
  q16_t sat_q;
  always_comb begin
    if (neg_r) begin
      sat_q = (ovf_r || quo_r >= 33'h080000000) ? q16_t'(32'sh80000000)
                                                : q16_t'(-quo_r[31:0]);
    end else begin
      sat_q = (ovf_r || quo_r >= 33'h07FFFFFFF) ? q16_t'(32'sh7FFFFFFF)
                                                : q16_t'(quo_r[31:0]);
    end
  end

  // Sequencer next state and integral update.
  always_comb begin
    state_nxt = state_r;
    integ_nxt = integ_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (src_r == SRC_OFF) begin
            integ_nxt = '0;
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_INT;
          end
        end
      end
      S_INT: begin
        integ_nxt = sat33({integ_r[31], integ_r} + {e_r[31], e_r});
        state_nxt = S_M1;
      end
      S_M1:  state_nxt = S_M2;
      S_M2:  state_nxt = S_M3;
      S_M3:  state_nxt = S_CLAMP;
      S_CLAMP: begin
        if (!clamped) begin
          state_nxt = S_WRITE;
        end else if (ki_r == '0) begin
          integ_nxt = '0;
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: state_nxt = S_ABS;
      S_ABS:  state_nxt = S_OVF;
      S_OVF:  state_nxt = ovf_now ? S_SAT : S_DIV;
      S_DIV:  state_nxt = (cnt_r == '0) ? S_SAT : S_DIV;
      S_SAT: begin
        integ_nxt = sat_q;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic out_load;
  assign out_load = (state_r == S_WRITE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      src_r       <= SRC_OFF;
      kp_r        <= '0;
      ki_r        <= '0;
      offs_r      <= '0;
      rg_r        <= '0;
      ub_r        <= '0;
      lb_r        <= '0;
    end else begin
      state_r <= state_nxt;
      integ_r <= integ_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SOURCE_SELECT: src_r  <= cfg_data[1:0];
          REG_PROP_GAIN:     kp_r   <= cfg_data;
          REG_INTEG_GAIN:    ki_r   <= cfg_data;
          REG_OFFSET_TERM:   offs_r <= cfg_data;
          REG_REF_GAIN:      rg_r   <= cfg_data;
          REG_UPPER_BOUND:   ub_r   <= cfg_data;
          REG_LOWER_BOUND:   lb_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (out_load) begin
      out_drive_r <= drive_r;
    end
    unique case (state_r)
      S_IDLE: begin
        ref_r   <= ref_sel;
        e_r     <= e_sel;
        drive_r <= '0;
      end
      S_M1:    acc_r <= prod_q + {{32{offs_r[31]}}, offs_r};
      S_M2:    acc_r <= acc_r + prod_q;
      S_M3: begin
        u1_r  <= acc_r;
        acc_r <= acc_r + prod_q;
      end
      S_CLAMP: begin
        acc_r   <= clamp_v;
        drive_r <= clamp_v[31:0];
      end
      S_DIFF:  acc_r <= acc_r - u1_r;
      S_ABS: begin
        neg_r <= acc_r[63] ^ ki_r[31];
        acc_r <= acc_r[63] ? -acc_r : acc_r;
        km_r  <= ki_r[31] ? 32'(-ki_r) : 32'(ki_r);
      end
      S_OVF: begin
        ovf_r <= ovf_now;
        rem_r <= acc_r[48:17];
        quo_r <= {acc_r[16:0], 16'd0};
        cnt_r <= 6'd32;
      end
      S_DIV: begin
        rem_r <= rem_step;
        quo_r <= {quo_r[31:0], q_bit};
        cnt_r <= cnt_r - 6'd1;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // A tick in progress blocks the next input word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input accepted again while a tick is in progress");

  // With the source off, the integral is cleared by the tick.
  a_off_clears_integ: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && src_r == SRC_OFF) |=> (integ_r == '0))
    else $error("integral not cleared with source off");

  // During division the partial remainder always stays below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < km_r))
    else $error("division remainder out of range");
`endif

endmodule

// File: tb/sv/piaw_drive_check.sv
// Checker for the PI controller core: tracks register writes, predicts the
// drive for every accepted tick and compares it with every accepted result.
// Depends on piaw_pkg for the data types and the register map.
module piaw_drive_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  piaw_pkg::q16_t                in_flow_measure,
  input  piaw_pkg::q16_t                in_flow_target,
  input  piaw_pkg::q16_t                in_gas_measure,
  input  piaw_pkg::q16_t                in_gas_limit,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  piaw_pkg::q16_t                out_drive_value,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  piaw_pkg::cfg_idx_t            cfg_index,
  input  logic [piaw_pkg::DATA_W-1:0]   cfg_data,
  output int                            mismatch_count,
  output int                            ticks_pending
);
  import piaw_pkg::*;

  localparam logic signed [127:0] WIDE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [127:0] WIDE_MIN = 32'sh8000_0000;

  logic [1:0] src_sel;
  q16_t       kp, ki, ff_offset, ff_gain, drive_hi, drive_lo;
  q16_t       integ_acc;
  q16_t       drive_expected[$];
  q16_t       exp_drive;

  function automatic q16_t clip32(logic signed [127:0] v);
    if (v > WIDE_MAX) return WIDE_MAX[31:0];
    if (v < WIDE_MIN) return WIDE_MIN[31:0];
    return v[31:0];
  endfunction

  // Q16.16 product, floored back to Q.16 at 64 bits.
  function automatic longint qprod(q16_t a, q16_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  // Back-calculated integral: (diff << 16) / k, truncated toward zero.
  function automatic q16_t backsolve(longint diff, q16_t k);
    logic signed [127:0] num, den, quo;
    num = diff;
    num = num <<< 16;
    den = k;
    quo = num / den;
    return clip32(quo);
  endfunction

  function automatic q16_t predict_drive(q16_t fm, q16_t ft, q16_t gm, q16_t gl);
    q16_t   setpoint, err;
    longint u_ff, u_tot;
    logic   hit;
    if (src_sel == SRC_OFF) begin
      integ_acc = '0;
      return '0;
    end
    setpoint = '0;
    err      = '0;
    if (src_sel == SRC_FLOW) begin
      setpoint = ft;
      err      = clip32(longint'(ft) - longint'(fm));
    end else if (src_sel == SRC_GAS) begin
      setpoint = gl;
      err      = clip32(longint'(gl) - longint'(gm));
    end
    integ_acc = clip32(longint'(integ_acc) + longint'(err));
    u_ff  = qprod(err, kp) + longint'(ff_offset) + qprod(ff_gain, setpoint);
    u_tot = u_ff + qprod(integ_acc, ki);
    hit   = 1'b0;
    // Upper bound first, so an inverted pair of bounds ends at the lower one.
    if (u_tot > longint'(drive_hi)) begin
      u_tot = drive_hi;
      hit   = 1'b1;
    end
    if (u_tot < longint'(drive_lo)) begin
      u_tot = drive_lo;
      hit   = 1'b1;
    end
    if (hit) integ_acc = (ki == 0) ? q16_t'(0) : backsolve(u_tot - u_ff, ki);
    return clip32(u_tot);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      src_sel   = SRC_OFF;
      kp        = '0;
      ki        = '0;
      ff_offset = '0;
      ff_gain   = '0;
      drive_hi  = '0;
      drive_lo  = '0;
      integ_acc = '0;
      drive_expected.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_SELECT: src_sel   = cfg_data[1:0];
          REG_PROP_GAIN:     kp        = cfg_data;
          REG_INTEG_GAIN:    ki        = cfg_data;
          REG_OFFSET_TERM:   ff_offset = cfg_data;
          REG_REF_GAIN:      ff_gain   = cfg_data;
          REG_UPPER_BOUND:   drive_hi  = cfg_data;
          REG_LOWER_BOUND:   drive_lo  = cfg_data;
          default: ;
        endcase
      end
      // Results are matched before this edge's tick is queued, since a word
      // leaving now can never belong to a tick entering now.
      if (out_valid && !out_stall) begin
        if (drive_expected.size() == 0) begin
          $error("drive_value: word with no tick pending, expected none, actual %0d",
                 out_drive_value);
          mismatch_count++;
        end else begin
          exp_drive = drive_expected.pop_front();
          if (out_drive_value !== exp_drive) begin
            $error("drive_value mismatch: expected %0d, actual %0d",
                   exp_drive, out_drive_value);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        drive_expected.push_back(predict_drive(in_flow_measure, in_flow_target,
                                               in_gas_measure, in_gas_limit));
    end
    ticks_pending = drive_expected.size();
  end

endmodule

// File: tb/sv/tb.sv
// Top of the PI controller testbench: clock, reset, directed and random
// ticks, register settings and output back-pressure. Depends on piaw_pkg,
// the core and the piaw_drive_check checker.
module tb;
  import piaw_pkg::*;

  localparam q16_t     Q_ONE        = 32'sh0001_0000;
  localparam q16_t     Q_MAX        = 32'sh7FFF_FFFF;
  localparam q16_t     Q_MIN        = 32'sh8000_0000;
  localparam cfg_idx_t REG_UNMAPPED = 3'd7;
  localparam int       STALL_LIMIT  = 5000;
  localparam int       LONG_HOLD    = 400;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid, in_stall;
  q16_t               in_flow_measure, in_flow_target, in_gas_measure, in_gas_limit;
  logic               out_valid, out_stall;
  q16_t               out_drive_value;
  logic               cfg_valid, cfg_ready;
  cfg_idx_t           cfg_index;
  logic [DATA_W-1:0]  cfg_data;
  int                 mismatch_count, ticks_pending;

  int                 burst_left;
  bit                 sending;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pi_controller_antiwindup_feedforward_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_flow_measure (in_flow_measure),
    .in_flow_target  (in_flow_target),
    .in_gas_measure  (in_gas_measure),
    .in_gas_limit    (in_gas_limit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_value (out_drive_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  piaw_drive_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_flow_measure (in_flow_measure),
    .in_flow_target  (in_flow_target),
    .in_gas_measure  (in_gas_measure),
    .in_gas_limit    (in_gas_limit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_value (out_drive_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .ticks_pending   (ticks_pending)
  );

  // Mostly mid-range values of random magnitude, with the extremes mixed in.
  function automatic q16_t pick_q16();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return ($urandom_range(0, 1) == 0) ? q16_t'(0) : q16_t'(-1);
      default: return $signed(raw) >>> $urandom_range(0, 24);
    endcase
  endfunction

  // Gains are kept small most of the time so the loop is not always clamped.
  function automatic q16_t pick_gain();
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 7) == 0) return pick_q16();
    return $signed(raw) >>> $urandom_range(12, 28);
  endfunction

  task automatic cfg_write(input cfg_idx_t idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [1:0] src, input q16_t p_gain, i_gain,
                               offset, r_gain, hi, lo);
    cfg_write(REG_SOURCE_SELECT, ($urandom & 32'hFFFF_FFFC) | src);
    cfg_write(REG_PROP_GAIN, p_gain);
    cfg_write(REG_INTEG_GAIN, i_gain);
    cfg_write(REG_OFFSET_TERM, offset);
    cfg_write(REG_REF_GAIN, r_gain);
    cfg_write(REG_UPPER_BOUND, hi);
    cfg_write(REG_LOWER_BOUND, lo);
    cfg_valid <= 1'b0;
  endtask

  // Returns at the edge that took the word; valid is left high for the next one.
  task automatic offer_tick(input q16_t fm, ft, gm, gl);
    in_valid        <= 1'b1;
    in_flow_measure <= fm;
    in_flow_target  <= ft;
    in_gas_measure  <= gm;
    in_gas_limit    <= gl;
    sending = 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 40);
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    in_valid <= 1'b0;
    sending = 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Drops valid and waits for every queued tick to come out.
  task automatic finish_phase();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    do @(negedge clk); while (ticks_pending != 0);
    @(posedge clk);
  endtask

  task automatic random_tick();
    q16_t ft, gl;
    q16_t fm, gm;
    logic [31:0] raw;
    ft = pick_q16();
    gl = pick_q16();
    raw = $urandom;
    fm = ($urandom_range(0, 9) < 6) ? ft + ($signed(raw) >>> $urandom_range(12, 30))
                                   : pick_q16();
    raw = $urandom;
    gm = ($urandom_range(0, 9) < 6) ? gl + ($signed(raw) >>> $urandom_range(12, 30))
                                   : pick_q16();
    offer_tick(fm, ft, gm, gl);
    pace_sender();
  endtask

  // Receiver back-pressure: segments of differing stall density, plus one
  // long hold-off once traffic is under way so the core backs up.
  initial begin : receiver
    int mode, seg_left, hold_left, results_taken;
    bit hold_done;
    out_stall <= 1'b0;
    mode = 0;
    seg_left = 0;
    hold_left = 0;
    results_taken = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) results_taken++;
      if (!hold_done && results_taken >= 300) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int   phase, i;
    q16_t a, b, hi, lo;
    logic [1:0] src;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_flow_measure <= '0;
    in_flow_target  <= '0;
    in_gas_measure  <= '0;
    in_gas_limit    <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_SOURCE_SELECT;
    cfg_data        <= '0;
    burst_left = 0;
    sending = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at reset: the source is off, so the drive stays zero.
    offer_tick(Q_MAX, Q_MIN, Q_MIN, Q_MAX);
    offer_tick(Q_MIN, Q_MAX, q16_t'(0), q16_t'(-1));
    finish_phase();

    // Flow feedback over the full range: the error and the integral saturate.
    apply_setting(SRC_FLOW, Q_ONE, Q_ONE >>> 1, q16_t'(0), q16_t'(0), Q_MAX, Q_MIN);
    offer_tick(Q_MIN, Q_MAX, q16_t'(0), q16_t'(0));
    offer_tick(Q_MIN, Q_MAX, q16_t'(0), q16_t'(0));
    offer_tick(Q_MAX, Q_MIN, q16_t'(0), q16_t'(0));
    offer_tick(Q_MAX, Q_MIN, q16_t'(0), q16_t'(0));
    offer_tick(Q_ONE, q16_t'(3 * 65536), Q_MAX, Q_MIN);
    offer_tick(q16_t'(0), q16_t'(0), Q_MAX, Q_MAX);
    finish_phase();

    // Gas feedback inside narrow bounds: clamps at both ends with back-calculation.
    apply_setting(SRC_GAS, q16_t'(2 * 65536), q16_t'(32'sh0000_4000), Q_ONE,
                  q16_t'(32'sh0000_8000), q16_t'(10 * 65536), q16_t'(-10 * 65536));
    offer_tick(Q_MIN, Q_MAX, q16_t'(0), q16_t'(20 * 65536));
    offer_tick(Q_MAX, Q_MIN, q16_t'(20 * 65536), q16_t'(0));
    offer_tick(q16_t'(0), q16_t'(0), Q_ONE, Q_ONE);
    offer_tick(q16_t'(0), q16_t'(0), Q_MIN, Q_MAX);
    finish_phase();

    // Reserved source with inverted bounds and no integral gain.
    apply_setting(SRC_RESERVED, Q_MAX, q16_t'(0), q16_t'(5 * 65536), Q_MAX,
                  -Q_ONE, Q_ONE);
    offer_tick(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    offer_tick(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    offer_tick(q16_t'(-1), q16_t'(0), q16_t'(1), q16_t'(-1));
    finish_phase();

    // Most negative gains everywhere.
    apply_setting(SRC_FLOW, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, q16_t'(0));
    offer_tick(Q_MAX, Q_MIN, q16_t'(0), q16_t'(0));
    offer_tick(Q_MIN, Q_MAX, q16_t'(0), q16_t'(0));
    offer_tick(q16_t'(1), q16_t'(-1), q16_t'(0), q16_t'(0));
    finish_phase();

    // A write to the unmapped index must change nothing; the source word
    // carries junk above its two bits.
    cfg_write(REG_UNMAPPED, $urandom);
    cfg_write(REG_SOURCE_SELECT, 32'hFFFF_FFFC | SRC_GAS);
    cfg_valid <= 1'b0;
    offer_tick(q16_t'(0), q16_t'(0), Q_ONE, q16_t'(0));
    offer_tick(q16_t'(0), q16_t'(0), q16_t'(0), Q_ONE);
    finish_phase();

    // Turning the source off clears the integral.
    cfg_write(REG_SOURCE_SELECT, 32'(SRC_OFF));
    cfg_valid <= 1'b0;
    offer_tick(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    finish_phase();

    for (phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 15))
        0: src = SRC_OFF;
        1: src = SRC_RESERVED;
        default: src = ($urandom_range(0, 1) == 0) ? SRC_FLOW : SRC_GAS;
      endcase
      a = pick_q16();
      b = pick_q16();
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      case ($urandom_range(0, 7))
        0: begin
          hi = Q_MAX;
          lo = Q_MIN;
        end
        1: begin
          hi = (a > b) ? b : a;
          lo = (a > b) ? a : b;
        end
        default: ;
      endcase
      apply_setting(src, pick_gain(), ($urandom_range(0, 7) == 0) ? q16_t'(0) : pick_gain(),
                    pick_q16(), pick_gain(), hi, lo);
      for (i = 0; i < 120; i++) random_tick();
      finish_phase();
    end

    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
